/* rtl/bhs_pkg.sv */
// ----------------------------------------------------------------------------
// bhs_pkg
// shared widths, action and status codes, controller/datapath interface types
// ----------------------------------------------------------------------------
package bhs_pkg;

  localparam int ACT_W     = 2;
  localparam int KEY_W     = 31;
  localparam int STAT_W    = 3;
  localparam int BKT_OUT_W = 4;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_DELETED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic cap;     // capture request, start remainder
    logic rd;      // read bucket row
    logic commit;  // update row, load result
  } cmd_t;

  typedef struct packed {
    logic mod_done;
  } sts_t;

endpackage

/* rtl/bhs_mod.sv */
// ----------------------------------------------------------------------------
// bhs_mod
// key modulo bucket count: reciprocal multiply for the quotient, then subtract
// ----------------------------------------------------------------------------
module bhs_mod #(
  parameter int NUM_BUCKETS = 10,
  parameter int BW          = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bhs_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [BW-1:0]             rem
);

  localparam int SH = bhs_pkg::KEY_W + $clog2(NUM_BUCKETS);
  localparam int MW = bhs_pkg::KEY_W + 2;
  localparam int PW = bhs_pkg::KEY_W + MW;
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) / 64'(NUM_BUCKETS)) + 64'd1);

  logic [bhs_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [bhs_pkg::KEY_W-1:0] quo_r, quo_nxt;
  logic [BW-1:0]             rem_r, rem_nxt;
  logic                      mul_r, mul_nxt;
  logic                      sub_r, sub_nxt;
  logic [PW-1:0]             prod;
  logic [BW-1:0]             quo_n;

  always_comb begin
    prod    = PW'(key_r) * PW'(RECIP);
    // low bits of quotient times bucket count are enough for the remainder
    quo_n   = quo_r[BW-1:0] * BW'(NUM_BUCKETS);
    key_nxt = key_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    mul_nxt = start;
    sub_nxt = mul_r;
    if (start) begin
      key_nxt = key;
    end
    if (mul_r) begin
      quo_nxt = (bhs_pkg::KEY_W)'(prod >> SH);
    end
    if (sub_r) begin
      rem_nxt = key_r[BW-1:0] - quo_n;
    end
  end

  assign done = sub_r;
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r <= 1'b0;
      sub_r <= 1'b0;
    end else begin
      mul_r <= mul_nxt;
      sub_r <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

endmodule

/* rtl/bhs_dp.sv */
// ----------------------------------------------------------------------------
// bhs_dp
// datapath: request registers, bucket row memory, slot valid bits,
// parallel slot compare and result registers
// ----------------------------------------------------------------------------
module bhs_dp #(
  parameter int NUM_BUCKETS      = 10,
  parameter int SLOTS_PER_BUCKET = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bhs_pkg::cmd_t                 cmd,
  output bhs_pkg::sts_t                 sts,
  input  logic [bhs_pkg::ACT_W-1:0]     in_action,
  input  logic [bhs_pkg::KEY_W-1:0]     in_key,
  output logic [bhs_pkg::STAT_W-1:0]    out_status,
  output logic [bhs_pkg::BKT_OUT_W-1:0] out_bucket
);

  localparam int BW    = $clog2(NUM_BUCKETS);
  localparam int SW    = SLOTS_PER_BUCKET;
  localparam int ROW_W = SW * bhs_pkg::KEY_W;

  logic [bhs_pkg::ACT_W-1:0]     act_r;
  logic [bhs_pkg::KEY_W-1:0]     key_r;
  logic [BW-1:0]                 bucket;
  logic                          mod_done;

  logic [ROW_W-1:0]              mem [NUM_BUCKETS];
  logic [ROW_W-1:0]              rd_row_r;
  logic [SW-1:0]                 vrow_r;
  logic [SW-1:0]                 valid_r [NUM_BUCKETS];

  logic [SW-1:0]                 free, free_oh, match, match_oh;
  logic                          any_free, any_match;
  logic [ROW_W-1:0]              wr_row;
  logic                          do_ins, do_del;
  logic [bhs_pkg::STAT_W-1:0]    status;
  logic [BW+bhs_pkg::BKT_OUT_W-1:0] bucket_ext;
  logic [bhs_pkg::STAT_W-1:0]    out_status_r;
  logic [bhs_pkg::BKT_OUT_W-1:0] out_bucket_r;

  bhs_mod #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .BW          (BW)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.cap),
    .key   (in_key),
    .done  (mod_done),
    .rem   (bucket)
  );

  assign sts.mod_done = mod_done;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      act_r <= in_action;
      key_r <= in_key;
    end
  end

  always_comb begin
    for (int s = 0; s < SW; s++) begin
      free[s]  = !vrow_r[s];
      match[s] = vrow_r[s] && (rd_row_r[s*bhs_pkg::KEY_W +: bhs_pkg::KEY_W] == key_r);
    end
    free_oh   = free & (~free + SW'(1));
    match_oh  = match & (~match + SW'(1));
    any_free  = |free;
    any_match = |match;
    for (int s = 0; s < SW; s++) begin
      wr_row[s*bhs_pkg::KEY_W +: bhs_pkg::KEY_W] =
        free_oh[s] ? key_r : rd_row_r[s*bhs_pkg::KEY_W +: bhs_pkg::KEY_W];
    end
    do_ins = (act_r == bhs_pkg::ACT_INSERT) && any_free;
    do_del = (act_r == bhs_pkg::ACT_DELETE) && any_match;
    case (act_r)
      bhs_pkg::ACT_INSERT: status = any_free ? bhs_pkg::ST_INSERTED : bhs_pkg::ST_FULL;
      bhs_pkg::ACT_SEARCH: status = any_match ? bhs_pkg::ST_FOUND : bhs_pkg::ST_NOT_FOUND;
      bhs_pkg::ACT_DELETE: status = any_match ? bhs_pkg::ST_DELETED : bhs_pkg::ST_NOT_FOUND;
      default:             status = bhs_pkg::ST_NOT_FOUND;
    endcase
  end

  // key row memory
  always_ff @(posedge clk) begin
    if (cmd.commit && do_ins) begin
      mem[bucket] <= wr_row;
    end
    if (cmd.rd) begin
      rd_row_r <= mem[bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      vrow_r <= valid_r[bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        valid_r[b] <= '0;
      end
    end else if (cmd.commit) begin
      if (do_ins) begin
        valid_r[bucket] <= vrow_r | free_oh;
      end else if (do_del) begin
        valid_r[bucket] <= vrow_r & ~match_oh;
      end
    end
  end

  assign bucket_ext = (BW + bhs_pkg::BKT_OUT_W)'(bucket);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= status;
      out_bucket_r <= bucket_ext[bhs_pkg::BKT_OUT_W-1:0];
    end
  end

  assign out_status = out_status_r;
  assign out_bucket = out_bucket_r;

endmodule

/* rtl/bhs_ctrl.sv */
// ----------------------------------------------------------------------------
// bhs_ctrl
// controller: request sequencing and result valid tracking
// ----------------------------------------------------------------------------
module bhs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output bhs_pkg::cmd_t cmd,
  input  bhs_pkg::sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_EVAL = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd.cap    = 1'b0;
    cmd.rd     = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("result not valid after commit");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_MOD))
    else $error("accepted request did not start remainder");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && out_valid_r && out_stall) |-> !cmd.commit)
    else $error("pending result overwritten");

  a_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mod_done |-> (state_r == S_MOD))
    else $error("remainder done outside its state");
`endif

endmodule

/* rtl/bucketed_hash_set.sv */
// ----------------------------------------------------------------------------
// bucketed_hash_set
// hash set of 31-bit keys in fixed-size buckets, bucket = key mod bucket count
// ----------------------------------------------------------------------------
// Each request carries an action (insert, search, delete) and a key and gives
// exactly one result with a status and the key's bucket. From acceptance to
// the next acceptance a request passes through an accept step, the remainder
// unit (reciprocal multiply, then subtract), one bucket row read and one
// evaluate/write-back step. A new request is accepted while the previous
// result still waits in the output register; evaluation holds until that
// register is free. Slot valid bits are flip-flops cleared at reset; stored
// keys sit in a row-per-bucket memory and need no clearing.
module bucketed_hash_set #(
  parameter int NUM_BUCKETS      = 10,
  parameter int SLOTS_PER_BUCKET = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bhs_pkg::ACT_W-1:0]     in_action,
  input  logic [bhs_pkg::KEY_W-1:0]     in_key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bhs_pkg::STAT_W-1:0]    out_status,
  output logic [bhs_pkg::BKT_OUT_W-1:0] out_bucket
);

  bhs_pkg::cmd_t cmd;
  bhs_pkg::sts_t sts;

  bhs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  bhs_dp #(
    .NUM_BUCKETS      (NUM_BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_action  (in_action),
    .in_key     (in_key),
    .out_status (out_status),
    .out_bucket (out_bucket)
  );

endmodule
